@@ hw/rtl/mts_pkg.sv @@
// mts_pkg: types and constants shared by the min tracking stack modules
// no dependencies; used by mts_ctrl, mts_datapath and min_tracking_stack

package mts_pkg;

   // stack depth and derived widths
   localparam int DEPTH    = 64;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int VAL_W    = 32;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

   typedef struct packed {
      logic                    cmd;
      logic signed [VAL_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] top_value;
      logic signed [VAL_W-1:0] min_value;
      logic [COUNT_W-1:0]      entry_count;
      logic                    is_empty;
      logic [STATUS_W-1:0]     status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic do_push;
      logic do_pop;
      logic load_top;
      logic emit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic deep;      // two or more entries held
      logic out_free;  // result register can take a new item
   } ctl_stat_type;

endpackage

@@ hw/rtl/mts_ram.sv @@
// mts_ram: generic single write port, single read port ram with registered read
// no dependencies

module mts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/mts_ctrl.sv @@
// mts_ctrl: sequencing state machine of the min tracking stack
// depends on mts_pkg

module mts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_cmd,
   output logic                  req_stall,
   input  mts_pkg::ctl_stat_type stat,
   output mts_pkg::ctl_cmd_type  ctl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == mts_pkg::CMD_PUSH) begin
                  ctl.do_push = 1'b1;
                  state_in    = ST_EMIT;
               end else begin
                  ctl.do_pop = 1'b1;
                  state_in   = stat.deep ? ST_WAIT : ST_EMIT;
               end
            end
         end
         ST_WAIT: begin
            ctl.load_top = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               ctl.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      stall_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

@@ hw/rtl/mts_datapath.sv @@
// mts_datapath: stack pointer, cached top entry, entry ram and result register
// depends on mts_pkg and mts_ram

module mts_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mts_pkg::req_type      req_data,
   input  mts_pkg::ctl_cmd_type  ctl,
   output mts_pkg::ctl_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mts_pkg::rsp_type      rsp_data
);

   localparam int RAM_W = 2 * mts_pkg::VAL_W;

   logic [mts_pkg::CNT_W-1:0]         sp_ff, sp_in;
   logic signed [mts_pkg::VAL_W-1:0]  top_val_ff, top_val_in;
   logic signed [mts_pkg::VAL_W-1:0]  top_min_ff, top_min_in;
   logic [mts_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   mts_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                              empty;
   logic                              full;
   logic signed [mts_pkg::VAL_W-1:0]  new_min;
   logic                              wr_en;
   logic [mts_pkg::ADDR_W-1:0]        wr_addr;
   logic [mts_pkg::ADDR_W-1:0]        rd_addr;
   logic [RAM_W-1:0]                  rd_data;

   assign empty = (sp_ff == '0);
   assign full  = (sp_ff >= mts_pkg::CNT_W'(mts_pkg::DEPTH));

   // a strictly smaller value becomes the new minimum
   assign new_min = (!empty && !($signed(req_data.push_value) < $signed(top_min_ff)))
                    ? top_min_ff : req_data.push_value;

   assign wr_en   = ctl.do_push && !full;
   assign wr_addr = sp_ff[mts_pkg::ADDR_W-1:0];
   // entry below the current top
   assign rd_addr = mts_pkg::ADDR_W'(sp_ff - mts_pkg::CNT_W'(2));

   mts_ram #(
      .WIDTH (RAM_W),
      .DEPTH (mts_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_data.push_value, new_min}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.deep     = (sp_ff >= mts_pkg::CNT_W'(2));
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sp_in      = sp_ff;
      top_val_in = top_val_ff;
      top_min_in = top_min_ff;
      status_in  = status_ff;
      if (ctl.do_push) begin
         if (full) begin
            status_in = mts_pkg::STATUS_PUSH_FULL;
         end else begin
            status_in  = mts_pkg::STATUS_OK;
            sp_in      = sp_ff + mts_pkg::CNT_W'(1);
            top_val_in = req_data.push_value;
            top_min_in = new_min;
         end
      end else if (ctl.do_pop) begin
         if (empty) begin
            status_in = mts_pkg::STATUS_POP_EMPTY;
         end else begin
            status_in = mts_pkg::STATUS_OK;
            sp_in     = sp_ff - mts_pkg::CNT_W'(1);
         end
      end else if (ctl.load_top) begin
         top_val_in = rd_data[RAM_W-1:mts_pkg::VAL_W];
         top_min_in = rd_data[mts_pkg::VAL_W-1:0];
      end
   end

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      if (ctl.emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.top_value   = empty ? '0 : top_val_ff;
         rsp_in.min_value   = empty ? '0 : top_min_ff;
         rsp_in.entry_count = mts_pkg::COUNT_W'(sp_ff);
         rsp_in.is_empty    = empty;
         rsp_in.status      = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_val_ff <= top_val_in;
      top_min_ff <= top_min_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hw/rtl/min_tracking_stack.sv @@
// min_tracking_stack: top level of the bounded stack with running minimum
// depends on mts_pkg, mts_ctrl, mts_datapath and mts_ram

// A bounded LIFO of signed 32-bit values that also reports the minimum of
// everything stored. Each item is a push (cmd 0) or a pop (cmd 1) and gives
// exactly one result item: new top, new minimum (both zero when empty),
// entry count, empty flag and status (ok, pop on empty ignored, push on
// full dropped). Every stored entry keeps the minimum of itself and all
// entries below it, so the minimum is always read off the top. The top
// entry is cached in registers; the full stack lives in a ram with a
// registered read port. A push, or a pop that leaves the stack empty, is
// loaded into the result register from the emit state once that register
// is free; a pop that leaves one or more entries first passes through a
// wait state for the ram read of the entry that becomes the new top.
// One item is worked on at a time, and the next can be accepted in the
// cycle after the previous result has been loaded into the result
// register, even while that result is still stalled. The ram needs no
// clearing after reset; entries above the count are never used.

module min_tracking_stack (
   input  logic             clock,
   input  logic             reset,
   // request items
   input  logic             req_valid,
   output logic             req_stall,
   input  mts_pkg::req_type req_data,
   // result items
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mts_pkg::rsp_type rsp_data
);

   // controller to datapath commands and status
   mts_pkg::ctl_cmd_type  ctl;
   mts_pkg::ctl_stat_type stat;

   // sequencing: accept, optional ram read, then load the result register
   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   // stack pointer, cached top, entry ram and result register
   mts_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // an empty stack reports zero for top and minimum
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_empty) |->
         (rsp_data.top_value == '0 && rsp_data.min_value == '0))
      else $error("empty stack result carries nonzero top or minimum");

   // the running minimum never exceeds the top value
   a_min_le_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_empty) |->
         ($signed(rsp_data.min_value) <= $signed(rsp_data.top_value)))
      else $error("minimum above top value");

   // an ignored pop can only happen on an empty stack
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == mts_pkg::STATUS_POP_EMPTY) |->
         rsp_data.is_empty)
      else $error("pop on empty flagged with entries held");

   // one item at a time: an accepted item blocks the next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while another is in flight");

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for the min tracking stack
// depends on mts_pkg and min_tracking_stack; holds its own stack model and
// compares every result item against it

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH   = mts_pkg::DEPTH;
   localparam int WATCHDOG_MAX  = 2000;   // cycles with no item moving on either side
   localparam int SETTLE_CYCLES = 10;
   localparam int REPORT_MAX    = 10;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mts_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mts_pkg::rsp_type rsp_data;

   // shadow copy of the stack: values and running minima per level
   logic signed [31:0] stack_values [STACK_DEPTH];
   logic signed [31:0] stack_minima [STACK_DEPTH];
   int                 stack_count = 0;

   mts_pkg::rsp_type   expected_results [$];
   int                 mismatch_count = 0;
   int                 idle_cycles    = 0;
   bit                 idle_off       = 1'b0;   // set for a stretch with no gaps or stalls

   min_tracking_stack u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // stack model: applies one accepted item and queues the result it gives
   // ------------------------------------------------------------------
   task automatic model_stack_op(input logic cmd, input logic signed [31:0] value);
      mts_pkg::rsp_type   result;
      logic signed [31:0] new_min;
      result        = '0;
      result.status = mts_pkg::STATUS_OK;
      if (cmd == mts_pkg::CMD_PUSH) begin
         if (stack_count >= STACK_DEPTH) begin
            // full: push is dropped, stack untouched
            result.status = mts_pkg::STATUS_PUSH_FULL;
         end else begin
            new_min = value;
            // only a strictly smaller value replaces the minimum
            if (stack_count > 0 && !(value < stack_minima[stack_count-1]))
               new_min = stack_minima[stack_count-1];
            stack_values[stack_count] = value;
            stack_minima[stack_count] = new_min;
            stack_count++;
         end
      end else begin
         if (stack_count == 0)
            result.status = mts_pkg::STATUS_POP_EMPTY;
         else
            stack_count--;
      end
      // empty stack reads top and minimum as zero
      if (stack_count > 0) begin
         result.top_value = stack_values[stack_count-1];
         result.min_value = stack_minima[stack_count-1];
         result.is_empty  = 1'b0;
      end else begin
         result.top_value = '0;
         result.min_value = '0;
         result.is_empty  = 1'b1;
      end
      result.entry_count = 7'(stack_count);
      expected_results.push_back(result);
   endtask

   // ------------------------------------------------------------------
   // sender: optional random gap, then hold the item until it is taken.
   // called and returning at a falling edge; valid stays high on return so
   // back-to-back items never drop it
   // ------------------------------------------------------------------
   task automatic send_item(input logic cmd, input logic signed [31:0] value);
      while (!idle_off && $urandom_range(0, 99) < 22) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_data.cmd        = cmd;
      req_data.push_value = value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model_stack_op(cmd, value);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      while (expected_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // values that favor extremes, ties and near-minimum cases
   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: v = 32'sh7fffffff;
               1: v = 32'sh80000000;
               2: v = 32'sh00000000;
               default: v = -32'sd1;
            endcase
         end
         1, 2: v = $signed(32'($urandom_range(0, 16))) - 32'sd8;
         3: v = (stack_count > 0) ?
                stack_minima[stack_count-1] + $signed(32'($urandom_range(0, 2))) - 32'sd1 :
                $signed($urandom);
         default: v = $signed($urandom);
      endcase
      return v;
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // empty pop, field extremes, ties on the minimum, unwinding to empty
   task automatic test_directed();
      send_item(mts_pkg::CMD_POP,  32'sh12345678);   // pop on empty, value ignored
      send_item(mts_pkg::CMD_PUSH, 32'sh7fffffff);
      send_item(mts_pkg::CMD_PUSH, 32'sd5);
      send_item(mts_pkg::CMD_PUSH, 32'sd5);          // equal, minimum kept
      send_item(mts_pkg::CMD_PUSH, 32'sh80000000);
      send_item(mts_pkg::CMD_PUSH, 32'sh80000000);   // equal to most negative
      send_item(mts_pkg::CMD_PUSH, -32'sd1);
      send_item(mts_pkg::CMD_PUSH, 32'sh55555555);
      send_item(mts_pkg::CMD_PUSH, 32'shaaaaaaaa);
      repeat (8) send_item(mts_pkg::CMD_POP, $signed($urandom));
      send_item(mts_pkg::CMD_POP,  32'shffffffff);   // empty again
      send_item(mts_pkg::CMD_PUSH, 32'sd0);
      send_item(mts_pkg::CMD_PUSH, -32'sd1);         // strictly smaller
      send_item(mts_pkg::CMD_POP,  32'sd0);          // minimum restores to zero
      send_item(mts_pkg::CMD_POP,  32'sd0);
      send_item(mts_pkg::CMD_POP,  32'sd0);          // pop on empty
   endtask

   // fill to the full depth, push on full, toggle at the boundary, then empty
   task automatic test_fill_and_empty();
      for (int i = 0; i < STACK_DEPTH; i++) send_item(mts_pkg::CMD_PUSH, pick_value());
      send_item(mts_pkg::CMD_PUSH, 32'sh80000000);   // dropped, must not become minimum
      send_item(mts_pkg::CMD_PUSH, pick_value());
      send_item(mts_pkg::CMD_POP,  pick_value());
      send_item(mts_pkg::CMD_PUSH, 32'sh80000000);   // refills the last level
      send_item(mts_pkg::CMD_PUSH, pick_value());    // full again
      for (int i = 0; i <= STACK_DEPTH; i++) send_item(mts_pkg::CMD_POP, pick_value());
   endtask

   // random walks in segments that lean toward push, pop or neither, so the
   // stack keeps visiting both the empty and the full end
   task automatic test_random_walk(input int n_items);
      int seg_left;
      int push_pct;
      seg_left = 0;
      push_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(30, 150);
            case ($urandom_range(0, 2))
               0: push_pct = 15;
               1: push_pct = 50;
               default: push_pct = 85;
            endcase
         end
         seg_left--;
         if ($urandom_range(0, 99) < push_pct)
            send_item(mts_pkg::CMD_PUSH, pick_value());
         else
            send_item(mts_pkg::CMD_POP, $signed($urandom));
      end
   endtask

   // sender holds off until every outstanding result has come back
   task automatic test_drain_pause();
      req_valid = 1'b0;
      wait_for_drain();
   endtask

   // back-to-back traffic with no gaps and no stalls
   task automatic test_full_rate(input int n_items);
      idle_off = 1'b1;
      test_random_walk(n_items);
      idle_off = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // result side: random stalls driven at the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_stall <= !idle_off && ($urandom_range(0, 99) < 22);
   end

   // compare each result item against the oldest expectation
   always @(posedge clock) begin : check_results
      mts_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result item: top %0d min %0d count %0d empty %0b status %0d",
                        rsp_data.top_value, rsp_data.min_value, rsp_data.entry_count,
                        rsp_data.is_empty, rsp_data.status);
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.top_value   !== want.top_value   ||
                rsp_data.min_value   !== want.min_value   ||
                rsp_data.entry_count !== want.entry_count ||
                rsp_data.is_empty    !== want.is_empty    ||
                rsp_data.status      !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"result mismatch: expected top %0d min %0d count %0d empty %0b ",
                            "status %0d, got top %0d min %0d count %0d empty %0b status %0d"},
                           want.top_value, want.min_value, want.entry_count,
                           want.is_empty, want.status,
                           rsp_data.top_value, rsp_data.min_value, rsp_data.entry_count,
                           rsp_data.is_empty, rsp_data.status);
            end
         end
      end
   end

   // watchdog: too long with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_MAX);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_fill_and_empty();
      test_random_walk(400);
      test_drain_pause();
      test_full_rate(200);
      test_random_walk(400);

      req_valid = 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
